// ===== rtl/assert_macros.svh =====
// Assertion macros for the header pool RTL; phpr_dp includes them.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/phpr_pkg.sv =====
// Shared constants and types of the packet header pool.
// No dependencies.
`default_nettype none

package phpr_pkg;

  localparam int DEFAULT_ENTRIES = 64;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 16;
  localparam int META_W   = 32;
  localparam int SUBS_W   = 8;

  // Command codes; code 3 is a no-op.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // One stored header entry.
  typedef struct packed {
    logic [SUBS_W-1:0] refs;
    logic [META_W-1:0] meta;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } phpr_entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic init_wr;  // write one link of the reset chain
    logic capture;  // latch the accepted item and start the reads
    logic exec;     // apply the item and load the result register
  } phpr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic init_last; // the last link of the reset chain is being written
  } phpr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/phpr_if.sv =====
// Valid/ready channel interfaces for the command and result items.
// Depends on phpr_pkg.
`default_nettype none

interface phpr_in_if #(
  parameter int ENTRIES = phpr_pkg::DEFAULT_ENTRIES
);
  import phpr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [$clog2(ENTRIES)-1:0] entry;
  logic [DATA_W-1:0]          data_ref;
  logic [LEN_W-1:0]           data_length;
  logic [META_W-1:0]          meta;
  logic [SUBS_W-1:0]          subscribers;

  modport source (output valid, command, entry, data_ref, data_length, meta, subscribers,
                  input ready);
  modport sink   (input valid, command, entry, data_ref, data_length, meta, subscribers,
                  output ready);
endinterface

interface phpr_out_if #(
  parameter int ENTRIES = phpr_pkg::DEFAULT_ENTRIES
);
  import phpr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic [$clog2(ENTRIES)-1:0]   entry_out;
  logic                         released;
  logic [DATA_W-1:0]            released_data;
  logic [LEN_W-1:0]             released_length;
  logic [META_W-1:0]            released_meta;
  logic [$clog2(ENTRIES+1)-1:0] free_count;

  modport source (output valid, status, entry_out, released, released_data,
                  released_length, released_meta, free_count,
                  input ready);
  modport sink   (input valid, status, entry_out, released, released_data,
                  released_length, released_meta, free_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/phpr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module phpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/phpr_ctrl.sv =====
// Sequencer of the header pool: reset link pass, accept, execute.
// Depends on phpr_pkg.
`default_nettype none

module phpr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  phpr_pkg::phpr_sts_t sts,
  output phpr_pkg::phpr_cmd_t cmd
);
  import phpr_pkg::*;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/phpr_dp.sv =====
// Datapath of the header pool: free list head and count, link and entry RAMs,
// captured item and result register. Depends on phpr_pkg, phpr_ram and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module phpr_dp #(
  parameter int ENTRIES = phpr_pkg::DEFAULT_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  phpr_pkg::phpr_cmd_t                  cmd,
  output phpr_pkg::phpr_sts_t                  sts,
  input  logic [phpr_pkg::CMD_W-1:0]           in_command,
  input  logic [$clog2(ENTRIES)-1:0]           in_entry,
  input  logic [phpr_pkg::DATA_W-1:0]          in_data_ref,
  input  logic [phpr_pkg::LEN_W-1:0]           in_data_length,
  input  logic [phpr_pkg::META_W-1:0]          in_meta,
  input  logic [phpr_pkg::SUBS_W-1:0]          in_subscribers,
  output logic [phpr_pkg::STATUS_W-1:0]        out_status,
  output logic [$clog2(ENTRIES)-1:0]           out_entry_out,
  output logic                                 out_released,
  output logic [phpr_pkg::DATA_W-1:0]          out_released_data,
  output logic [phpr_pkg::LEN_W-1:0]           out_released_length,
  output logic [phpr_pkg::META_W-1:0]          out_released_meta,
  output logic [$clog2(ENTRIES+1)-1:0]         out_free_count
);
  import phpr_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW:0]   ENTRIES_X = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [IW-1:0] init_idx_r;

  logic [CMD_W-1:0]  cap_cmd_r;
  logic [IW-1:0]     cap_idx_r;
  logic [DATA_W-1:0] cap_data_r;
  logic [LEN_W-1:0]  cap_len_r;
  logic [META_W-1:0] cap_meta_r;
  logic [SUBS_W-1:0] cap_subs_r;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IW-1:0]       entry_out_r, entry_out_nxt;
  logic                released_r, released_nxt;
  logic [DATA_W-1:0]   rel_data_r, rel_data_nxt;
  logic [LEN_W-1:0]    rel_len_r, rel_len_nxt;
  logic [META_W-1:0]   rel_meta_r, rel_meta_nxt;
  logic [CW-1:0]       free_count_r;

  logic          link_we, free_we;
  logic [IW-1:0] link_waddr, link_wdata, link_rdata;
  logic          pay_we;
  logic [IW-1:0] pay_waddr;
  phpr_entry_t   pay_wdata, pay_rdata;
  logic          idx_ok;
  logic          alloc_go, free_go;

  assign sts.init_last = (init_idx_r == LAST_IDX);
  assign idx_ok        = ({1'b0, cap_idx_r} < ENTRIES_X);

  // Link RAM: the reset pass writes i -> i+1 (last -> 0), a free pushes.
  assign link_we    = cmd.init_wr || free_we;
  assign link_waddr = cmd.init_wr ? init_idx_r : cap_idx_r;
  assign link_wdata = cmd.init_wr ? (sts.init_last ? '0 : init_idx_r + 1'b1) : head_r;

  phpr_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.capture),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  phpr_ram #(.WIDTH($bits(phpr_entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (cmd.capture && ({1'b0, in_entry} < ENTRIES_X)),
    .raddr (in_entry),
    .rdata (pay_rdata)
  );

  always_comb begin
    head_nxt      = head_r;
    total_nxt     = total_r;
    free_we       = 1'b0;
    pay_we        = 1'b0;
    pay_waddr     = cap_idx_r;
    pay_wdata     = pay_rdata;
    status_nxt    = STATUS_OK;
    entry_out_nxt = '0;
    released_nxt  = 1'b0;
    rel_data_nxt  = '0;
    rel_len_nxt   = '0;
    rel_meta_nxt  = '0;
    case (cap_cmd_r)
      CMD_ALLOC: begin
        if (total_r != '0) begin
          pay_we           = cmd.exec;
          pay_waddr        = head_r;
          pay_wdata.refs   = cap_subs_r;
          pay_wdata.meta   = cap_meta_r;
          pay_wdata.length = cap_len_r;
          pay_wdata.data   = cap_data_r;
          head_nxt         = link_rdata;
          total_nxt        = total_r - 1'b1;
          entry_out_nxt    = head_r;
        end else begin
          status_nxt = STATUS_EMPTY;
        end
      end
      CMD_FREE: begin
        if (total_r == FULL_CNT) begin
          status_nxt = STATUS_FULL;
        end else if (idx_ok) begin
          free_we   = cmd.exec;
          head_nxt  = cap_idx_r;
          total_nxt = total_r + 1'b1;
        end
      end
      CMD_ACK: begin
        if (idx_ok && pay_rdata.refs != '0) begin
          pay_we         = cmd.exec;
          pay_wdata.refs = pay_rdata.refs - 1'b1;
          if (pay_rdata.refs == SUBS_W'(1)) begin
            released_nxt  = 1'b1;
            entry_out_nxt = cap_idx_r;
            rel_data_nxt  = pay_rdata.data;
            rel_len_nxt   = pay_rdata.length;
            rel_meta_nxt  = pay_rdata.meta;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      total_r    <= FULL_CNT;
      init_idx_r <= '0;
    end else begin
      if (cmd.init_wr) begin
        init_idx_r <= init_idx_r + 1'b1;
      end
      if (cmd.exec) begin
        head_r  <= head_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_cmd_r  <= in_command;
      cap_idx_r  <= in_entry;
      cap_data_r <= in_data_ref;
      cap_len_r  <= in_data_length;
      cap_meta_r <= in_meta;
      cap_subs_r <= in_subscribers;
    end
    if (cmd.exec) begin
      status_r     <= status_nxt;
      entry_out_r  <= entry_out_nxt;
      released_r   <= released_nxt;
      rel_data_r   <= rel_data_nxt;
      rel_len_r    <= rel_len_nxt;
      rel_meta_r   <= rel_meta_nxt;
      free_count_r <= total_nxt;
    end
  end

  assign out_status          = status_r;
  assign out_entry_out       = entry_out_r;
  assign out_released        = released_r;
  assign out_released_data   = rel_data_r;
  assign out_released_length = rel_len_r;
  assign out_released_meta   = rel_meta_r;
  assign out_free_count      = free_count_r;

  assign alloc_go = cmd.exec && (cap_cmd_r == CMD_ALLOC) && (total_r != '0);
  assign free_go  = cmd.exec && (cap_cmd_r == CMD_FREE) && (total_r != FULL_CNT) && idx_ok;

  `ASSERT_CLK(a_total_bound, clk, rst_n, total_r <= FULL_CNT, "free count above pool size")
  `ASSERT_CLK(a_pop, clk, rst_n, alloc_go |=> total_r == $past(total_r) - 1'b1, "pop missing")
  `ASSERT_CLK(a_push, clk, rst_n, free_go |=> head_r == $past(cap_idx_r), "free did not push")

endmodule

`default_nettype wire

// ===== rtl/packet_header_pool_refcount.sv =====
// Packet header pool with reference counts. A pool of ENTRIES header entries
// sits on a last-in first-out free list. Allocate pops the head entry and
// stores data reference, length, meta word and subscriber count; free pushes
// an entry back (status FULL when the pool is already full); acknowledge
// decrements a nonzero use count and, when it reaches zero, returns the
// entry's stored fields with released set. Every command returns exactly one
// result carrying the free count after the command.
//
// Timing: an item has an accept cycle, which issues the registered reads of
// the link RAM and the entry RAM, and an execute cycle, which writes back and
// loads the result register. The next item is taken in the cycle after
// execute, so no new item is taken before the last one is executed; a result
// left waiting holds the next execute, not the next accept. After reset the
// block writes the initial free chain into the link RAM, one link a cycle,
// ENTRIES links (64 by default), with in_ch.ready low. Entry fields of a
// never allocated entry are undefined.
`default_nettype none

module packet_header_pool_refcount #(
  parameter int ENTRIES = phpr_pkg::DEFAULT_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  phpr_in_if.sink   in_ch,
  phpr_out_if.source out_ch
);
  import phpr_pkg::*;

  phpr_cmd_t cmd;
  phpr_sts_t sts;

  // Sequence the reset pass and each accepted item.
  phpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the free list, the stored entries and the result register.
  phpr_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_ch.command),
    .in_entry            (in_ch.entry),
    .in_data_ref         (in_ch.data_ref),
    .in_data_length      (in_ch.data_length),
    .in_meta             (in_ch.meta),
    .in_subscribers      (in_ch.subscribers),
    .out_status          (out_ch.status),
    .out_entry_out       (out_ch.entry_out),
    .out_released        (out_ch.released),
    .out_released_data   (out_ch.released_data),
    .out_released_length (out_ch.released_length),
    .out_released_meta   (out_ch.released_meta),
    .out_free_count      (out_ch.free_count)
  );

endmodule

`default_nettype wire
